// ----- rtl/core/ndq_pkg.sv -----
// ndq_pkg: shared types, constants and binary16 helper functions for the
// nibble dequantiser. No dependencies.
package ndq_pkg;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	localparam logic [15:0] HALF_QNAN = 16'h7E00;
	localparam logic [14:0] HALF_INF  = 15'h7C00;

	// binary32 1/15 = 0x888889 * 2^-27
	localparam logic [23:0] RECIP15_MANT = 24'h888889;
	localparam int          RECIP15_SHIFT = 27;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	typedef struct packed {
		logic [15:0] gmin;
		logic [15:0] step;
		logic [7:0]  dbyte;
		logic        last;
	} ndq_entry_t;

	typedef struct packed {
		logic       push;
		ndq_entry_t entry;
	} ndq_push_t;

	typedef struct packed {
		logic       not_empty;
		logic       full;
		ndq_entry_t entry;
	} ndq_qstat_t;

	function automatic logic half_is_nan(input logic [15:0] h);
		return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
	endfunction

	function automatic logic half_is_inf(input logic [15:0] h);
		return (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
	endfunction

	function automatic logic half_is_zero(input logic [15:0] h);
		return h[14:0] == 15'd0;
	endfunction

	// magnitude of a finite binary16 as an integer count of 2^-24
	function automatic logic [40:0] half_to_fix(input logic [15:0] h);
		logic [40:0] m;
		m = {30'd0, 1'b1, h[9:0]};
		if (h[14:10] == 5'd0)
			return {31'd0, h[9:0]};
		return m << (h[14:10] - 5'd1);
	endfunction

	// index of the highest set bit (0 for zero)
	function automatic logic [5:0] lead_pos(input logic [63:0] x);
		logic [5:0] p;
		p = 6'd0;
		for (int i = 0; i < 64; i++)
			if (x[i])
				p = i[5:0];
		return p;
	endfunction

	// right shift with round to nearest, ties to even
	function automatic logic [63:0] rne_shift(input logic [63:0] x, input logic [6:0] s);
		logic [63:0] q;
		logic [63:0] mask;
		logic        g;
		logic        st;
		if (s == 7'd0)
			return x;
		if (s[6])
			return 64'd0;
		q    = x >> s[5:0];
		g    = x[s[5:0] - 6'd1];
		mask = (64'd1 << (s[5:0] - 6'd1)) - 64'd1;
		st   = |(x & mask);
		return q + {63'd0, g & (st | q[0])};
	endfunction

	// binary16 magnitude bits from x rounded right by s, exponent field base t
	function automatic logic [14:0] half_pack(input logic [63:0] x, input logic [6:0] s,
			input logic [5:0] t);
		logic [63:0] sum;
		sum = ({58'd0, t} << 10) + rne_shift(x, s);
		if (sum >= 64'h7C00)
			return HALF_INF;
		return sum[14:0];
	endfunction

endpackage

// ----- rtl/core/ndq_in_if.sv -----
// ndq_in_if: input channel of the nibble dequantiser, valid/ready plus the
// header or data byte payload. No dependencies.
interface ndq_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] group_min;
	logic [15:0] group_max;
	logic [7:0]  data_byte;

	modport source(output valid, kind, group_min, group_max, data_byte, input ready);
	modport sink(input valid, kind, group_min, group_max, data_byte, output ready);
endinterface

// ----- rtl/core/ndq_out_if.sv -----
// ndq_out_if: result channel of the nibble dequantiser, valid/ready plus two
// binary16 values and the group end flag. No dependencies.
interface ndq_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] value_even;
	logic [15:0] value_odd;
	logic        last_in_group;

	modport source(output valid, value_even, value_odd, last_in_group, input ready);
	modport sink(input valid, value_even, value_odd, last_in_group, output ready);
endinterface

// ----- rtl/core/ndq_front.sv -----
// ndq_front: accepts items, computes the binary16 step of each header in an
// eight stage pipeline, keeps min/step/byte counter and pushes data bytes.
// Depends on ndq_pkg and ndq_in_if.
module ndq_front #(
	parameter int GROUP_ELEMENTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ndq_in_if.sink                din,
	input  logic                  q_full,
	output ndq_pkg::ndq_push_t    push
);
	import ndq_pkg::*;

	localparam int BYTES = (GROUP_ELEMENTS / 2 > 0) ? GROUP_ELEMENTS / 2 : 1;
	localparam int IDX_W = (BYTES > 1) ? $clog2(BYTES) : 1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  dbyte;
		logic [15:0] gmin;
		logic [15:0] gmax;
		logic        snan;
		logic        sinf;
		logic        sneg;
		logic        szero;
		logic [41:0] mag;
		logic [5:0]  lead;
		logic [24:0] mant;
		logic [4:0]  k;
		logic [48:0] prod;
		logic [24:0] q2;
		logic [5:0]  t;
		logic [6:0]  sh;
	} fr_t;

	fr_t st_s1, st_s2, st_s3, st_s4, st_s5, st_s6, st_s7, st_s8;
	fr_t c1, c2, c3, c4, c5, c6, c7;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic adv;

	logic [15:0]      offset_q, step_q, step_new;
	logic [IDX_W-1:0] idx_q;
	logic             last;

	logic [40:0]        lo_fix, hi_fix;
	logic signed [41:0] lo_v, hi_v, dif;
	logic               lo_nan, hi_nan, lo_inf, hi_inf;
	logic [5:0]         s4_sh, s7_sh, l3;
	logic signed [8:0]  k3, p3;

	assign adv       = !(v_s8 && st_s8.kind == KIND_DATA && q_full);
	assign din.ready = adv;

	always_comb begin
		c1       = st_s1;
		c1.kind  = din.kind;
		c1.dbyte = din.data_byte;
		c1.gmin  = din.group_min;
		c1.gmax  = din.group_max;

		// exact difference max - min in units of 2^-24
		c2     = st_s1;
		lo_fix = half_to_fix(st_s1.gmin);
		hi_fix = half_to_fix(st_s1.gmax);
		lo_v   = st_s1.gmin[15] ? -$signed({1'b0, lo_fix}) : $signed({1'b0, lo_fix});
		hi_v   = st_s1.gmax[15] ? -$signed({1'b0, hi_fix}) : $signed({1'b0, hi_fix});
		dif    = hi_v - lo_v;
		lo_nan = half_is_nan(st_s1.gmin);
		hi_nan = half_is_nan(st_s1.gmax);
		lo_inf = half_is_inf(st_s1.gmin);
		hi_inf = half_is_inf(st_s1.gmax);
		c2.snan  = lo_nan || hi_nan || (lo_inf && hi_inf && st_s1.gmin[15] == st_s1.gmax[15]);
		c2.sinf  = lo_inf || hi_inf;
		c2.szero = (dif == 42'sd0);
		c2.mag   = dif[41] ? 42'(-dif) : 42'(dif);
		if (lo_inf || hi_inf)
			c2.sneg = hi_inf ? st_s1.gmax[15] : !st_s1.gmin[15];
		else if (dif == 42'sd0)
			c2.sneg = half_is_zero(st_s1.gmin) && half_is_zero(st_s1.gmax)
				&& st_s1.gmax[15] && !st_s1.gmin[15];
		else
			c2.sneg = dif[41];

		c3      = st_s2;
		c3.lead = lead_pos({22'd0, st_s2.mag});

		// round to binary32 precision
		c4     = st_s3;
		s4_sh  = (st_s3.lead > 6'd23) ? st_s3.lead - 6'd23 : 6'd0;
		c4.mant = 25'(rne_shift({22'd0, st_s3.mag}, {1'b0, s4_sh}));
		c4.k    = s4_sh[4:0];

		c5      = st_s4;
		c5.prod = {24'd0, st_s4.mant} * {25'd0, RECIP15_MANT};

		c6      = st_s5;
		c6.lead = lead_pos({15'd0, st_s5.prod});

		// product back to binary32, then place for the binary16 rounding
		c7    = st_s6;
		s7_sh = (st_s6.lead > 6'd23) ? st_s6.lead - 6'd23 : 6'd0;
		c7.q2 = 25'(rne_shift({15'd0, st_s6.prod}, {1'b0, s7_sh}));
		l3    = (s7_sh == 6'd0) ? st_s6.lead : (c7.q2[24] ? 6'd24 : 6'd23);
		k3    = $signed({4'd0, st_s6.k}) - 9'(RECIP15_SHIFT) + $signed({3'd0, s7_sh});
		p3    = k3 + $signed({3'd0, l3});
		c7.t  = (p3 > 9'sd10) ? 6'(p3 - 9'sd10) : 6'd0;
		c7.sh = 7'($signed({3'd0, c7.t}) - k3);
	end

	always_comb begin
		if (st_s8.snan)
			step_new = HALF_QNAN;
		else if (st_s8.sinf)
			step_new = {st_s8.sneg, HALF_INF};
		else if (st_s8.szero)
			step_new = {st_s8.sneg, 15'd0};
		else
			step_new = {st_s8.sneg, half_pack({39'd0, st_s8.q2}, st_s8.sh, st_s8.t)};
	end

	assign last = (idx_q >= IDX_W'(BYTES - 1));

	always_comb begin
		push.push        = adv && v_s8 && st_s8.kind == KIND_DATA;
		push.entry.gmin  = offset_q;
		push.entry.step  = step_q;
		push.entry.dbyte = st_s8.dbyte;
		push.entry.last  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
			offset_q <= '0;
			step_q   <= '0;
			idx_q    <= '0;
		end else if (adv) begin
			v_s1 <= din.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			if (v_s8) begin
				if (st_s8.kind == KIND_HEADER) begin
					offset_q <= st_s8.gmin;
					step_q   <= step_new;
					idx_q    <= '0;
				end else begin
					idx_q <= last ? '0 : idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= c1;
			st_s2 <= c2;
			st_s3 <= c3;
			st_s4 <= c4;
			st_s5 <= c5;
			st_s6 <= c6;
			st_s7 <= c7;
			st_s8 <= st_s7;
		end
	end

endmodule

// ----- rtl/core/ndq_queue.sv -----
// ndq_queue: four entry FIFO between the front and back parts.
// Depends on ndq_pkg.
module ndq_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  ndq_pkg::ndq_push_t  push,
	input  logic                pop,
	output ndq_pkg::ndq_qstat_t stat
);
	import ndq_pkg::*;

	ndq_entry_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_q, rd_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;
	logic                   do_push, do_pop;

	assign stat.not_empty = (cnt_q != '0);
	assign stat.full      = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign stat.entry     = mem_q[rd_q];
	assign do_push        = push.push && !stat.full;
	assign do_pop         = pop && stat.not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + QUEUE_PTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + QUEUE_PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + QUEUE_CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - QUEUE_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push.entry;
	end

endmodule

// ----- rtl/core/ndq_back.sv -----
// ndq_back: restores two binary16 values per data byte as min + code*step
// with one rounding, four stages ending in the output register.
// Depends on ndq_pkg and ndq_out_if.
module ndq_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ndq_pkg::ndq_qstat_t stat,
	output logic                pop,
	ndq_out_if.source           dout
);
	import ndq_pkg::*;

	typedef struct packed {
		logic [40:0] min_fix;
		logic [44:0] prod;
		logic        min_s;
		logic        step_s;
		logic        nan;
		logic        inf;
		logic        infs;
		logic        zs;
		logic        neg;
		logic [44:0] mag;
		logic [5:0]  lead;
	} ln_t;

	typedef struct packed {
		ln_t [1:0] lane;
		logic      last;
	} bk_t;

	bk_t  st_s1, st_s2, st_s3, c1, c2, c3;
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;
	logic [15:0] val_s4 [2];
	logic [15:0] val_n [2];
	logic        last_s4;

	logic [3:0]         code;
	logic [40:0]        step_fix;
	logic               m_nan, m_inf, s_nan, s_inf, s_zero, m_zero;
	logic signed [45:0] mv, pv, sum;
	logic [5:0]         t;

	assign adv = !v_s4 || dout.ready;
	assign pop = adv && stat.not_empty;

	always_comb begin
		c1      = st_s1;
		c1.last = stat.entry.last;
		step_fix = half_to_fix(stat.entry.step);
		m_nan  = half_is_nan(stat.entry.gmin);
		m_inf  = half_is_inf(stat.entry.gmin);
		m_zero = half_is_zero(stat.entry.gmin);
		s_nan  = half_is_nan(stat.entry.step);
		s_inf  = half_is_inf(stat.entry.step);
		s_zero = half_is_zero(stat.entry.step);
		code   = 4'd0;
		for (int i = 0; i < 2; i++) begin
			code = (i == 0) ? stat.entry.dbyte[3:0] : stat.entry.dbyte[7:4];
			c1.lane[i].min_fix = half_to_fix(stat.entry.gmin);
			c1.lane[i].prod    = {4'd0, step_fix} * {41'd0, code};
			c1.lane[i].min_s   = stat.entry.gmin[15];
			c1.lane[i].step_s  = stat.entry.step[15];
			c1.lane[i].nan     = m_nan || s_nan || (s_inf && code == 4'd0)
				|| (s_inf && m_inf && stat.entry.gmin[15] != stat.entry.step[15]);
			c1.lane[i].inf     = s_inf || m_inf;
			c1.lane[i].infs    = m_inf ? stat.entry.gmin[15] : stat.entry.step[15];
			c1.lane[i].zs      = m_zero && (code == 4'd0 || s_zero)
				&& stat.entry.gmin[15] && stat.entry.step[15];
		end

		c2  = st_s1;
		mv  = '0;
		pv  = '0;
		sum = '0;
		for (int i = 0; i < 2; i++) begin
			mv  = st_s1.lane[i].min_s ? -$signed({5'd0, st_s1.lane[i].min_fix})
				: $signed({5'd0, st_s1.lane[i].min_fix});
			pv  = st_s1.lane[i].step_s ? -$signed({1'b0, st_s1.lane[i].prod})
				: $signed({1'b0, st_s1.lane[i].prod});
			sum = mv + pv;
			c2.lane[i].neg = sum[45];
			c2.lane[i].mag = sum[45] ? 45'(-sum) : 45'(sum);
		end

		c3 = st_s2;
		for (int i = 0; i < 2; i++)
			c3.lane[i].lead = lead_pos({19'd0, st_s2.lane[i].mag});

		t = 6'd0;
		for (int i = 0; i < 2; i++) begin
			t = (st_s3.lane[i].lead > 6'd10) ? st_s3.lane[i].lead - 6'd10 : 6'd0;
			if (st_s3.lane[i].nan)
				val_n[i] = HALF_QNAN;
			else if (st_s3.lane[i].inf)
				val_n[i] = {st_s3.lane[i].infs, HALF_INF};
			else if (st_s3.lane[i].mag == 45'd0)
				val_n[i] = {st_s3.lane[i].zs, 15'd0};
			else
				val_n[i] = {st_s3.lane[i].neg,
					half_pack({19'd0, st_s3.lane[i].mag}, {1'b0, t}, t)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			{v_s1, v_s2, v_s3, v_s4} <= '0;
		else if (adv) begin
			v_s1 <= stat.not_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1     <= c1;
			st_s2     <= c2;
			st_s3     <= c3;
			val_s4[0] <= val_n[0];
			val_s4[1] <= val_n[1];
			last_s4   <= st_s3.last;
		end
	end

	assign dout.valid         = v_s4;
	assign dout.value_even    = val_s4[0];
	assign dout.value_odd     = val_s4[1];
	assign dout.last_in_group = last_s4;

endmodule

// ----- rtl/core/nibble_dequant_fp16.sv -----
// nibble_dequant_fp16: top level of the int4 group dequantiser to binary16.
// Depends on ndq_pkg, ndq_in_if, ndq_out_if, ndq_front, ndq_queue, ndq_back.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+---------------------------------------------
//  din     | in  | valid/ready  | kind, group_min, group_max, data_byte
//  dout    | out | valid/ready  | value_even, value_odd, last_in_group
//
// One item per cycle unless stalled: headers and data bytes share the front
// pipeline, so a header's step is in place before the next byte reaches the
// queue. Path: 8 front stages, the queue, 4 back stages (output register).
// Reset (arst_n low, asynchronous) gives min +0.0, step +0.0, counter 0.
// A stalled dout fills the 4 entry queue before din.ready drops; headers
// still leave the front while the queue is full unless a byte sits ahead.
module nibble_dequant_fp16 #(
	parameter int GROUP_ELEMENTS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	ndq_in_if.sink    din,
	ndq_out_if.source dout
);
	import ndq_pkg::*;

	ndq_push_t  push;
	ndq_qstat_t stat;
	logic       pop;

	// front: accepts transactions, computes header steps, tags group ends
	ndq_front #(
		.GROUP_ELEMENTS(GROUP_ELEMENTS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din),
		.q_full(stat.full),
		.push  (push)
	);

	// decoupling queue between the two halves
	ndq_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.stat  (stat)
	);

	// back: fused min + code*step for both nibbles
	ndq_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.pop   (pop),
		.dout  (dout)
	);

endmodule

// ----- tb/tb_nibble_dequant_fp16.sv -----
// tb_nibble_dequant_fp16: self-checking testbench for the int4 to binary16 group dequantiser.
// Depends on ndq_pkg, ndq_in_if, ndq_out_if and the nibble_dequant_fp16 RTL.
// Runs a directed table first, then random groups; checks results against a predictor or the table.
`timescale 1ns / 1ps

module tb_nibble_dequant_fp16;
	import ndq_pkg::*;

	localparam int GROUP_ELEMENTS = 64;
	localparam int GROUP_BYTES    = (GROUP_ELEMENTS / 2) > 0 ? (GROUP_ELEMENTS / 2) : 1;
	localparam int IDLE_PCT       = 36;
	localparam int HOLD_CYCLES    = 80;

	typedef struct {
		logic        kind;
		logic [15:0] gmin;
		logic [15:0] gmax;
		logic [7:0]  dbyte;
		bit          typed;	// expected result written in the table
		logic [15:0] t_even;
		logic [15:0] t_odd;
		logic        t_last;
	} stim_t;

	typedef struct {
		logic [15:0] even;
		logic [15:0] odd;
		logic        last;
	} dq_res_t;

	logic clk;
	logic arst_n;

	ndq_in_if  din ();
	ndq_out_if dout ();

	nibble_dequant_fp16 #(.GROUP_ELEMENTS(GROUP_ELEMENTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din.sink),
		.dout   (dout.source)
	);

	stim_t   stim[$];
	dq_res_t pending_values[$];
	int      n_fail;
	int      n_accepted;
	int      cyc;
	bit      hold_req;

	// predictor state
	logic [15:0] p_min;
	logic [15:0] p_step;
	int          p_idx;

	always #1 clk = ~clk;

	// ---------------------------------------------------------------- binary16 arithmetic
	function automatic real half_val(input logic [15:0] h);
		int  e;
		int  f;
		real mag;
		e = int'(h[14:10]);
		f = int'(h[9:0]);
		if (e == 31)
			mag = (f != 0) ? $bitstoreal(64'h7FF8000000000000)
				: $bitstoreal(64'h7FF0000000000000);
		else if (e == 0)
			mag = real'(f) * 2.0 ** (-24);
		else
			mag = real'(1024 + f) * 2.0 ** (e - 25);
		return h[15] ? -mag : mag;
	endfunction

	// one nearest-even rounding of a double to binary16, subnormals kept
	function automatic logic [15:0] to_half(input real x);
		logic [63:0] b;
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] hlf;
		logic [15:0] s;
		logic [15:0] base;
		int          e;
		int          ee;
		int          sh;
		b = $realtobits(x);
		s = b[63] ? 16'h8000 : 16'h0000;
		e = int'(b[62:52]);
		m = {12'd0, b[51:0]};
		if (e == 2047)
			return (m != 0) ? HALF_QNAN : (s | 16'h7C00);
		if (e == 0)
			return s;
		ee = e - 1023;
		if (ee > 15)
			return s | 16'h7C00;
		if (ee < -25)
			return s;
		m = m | (64'd1 << 52);
		if (ee >= -14) begin
			sh   = 42;
			base = 16'(ee + 14) << 10;
		end else begin
			sh   = 42 + (-14 - ee);
			base = 16'd0;
		end
		q   = m >> sh;
		rem = m & ((64'd1 << sh) - 64'd1);
		hlf = 64'd1 << (sh - 1);
		if (rem > hlf || (rem == hlf && q[0]))
			q = q + 64'd1;
		return s | (base + q[15:0]);
	endfunction

	// nearest-even rounding to binary32 precision; range never leaves binary32 normals here
	function automatic real to_single(input real x);
		logic [63:0] b;
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] rem;
		int          e;
		real         r;
		b = $realtobits(x);
		e = int'(b[62:52]);
		if (e == 2047 || e == 0)
			return x;
		m   = {11'd1, b[51:0]};
		q   = m >> 29;
		rem = m & 64'h1FFFFFFF;
		if (rem > 64'h10000000 || (rem == 64'h10000000 && q[0]))
			q = q + 64'd1;
		r = real'(q) * 2.0 ** (e - 1023 - 23);
		return b[63] ? -r : r;
	endfunction

	function automatic logic [15:0] restore_code(input logic [3:0] code);
		return to_half(half_val(p_min) + real'(code) * half_val(p_step));
	endfunction

	// advances the predictor by one transaction; returns 1 when a result is due
	function automatic bit predict(input stim_t it, output dq_res_t r);
		real diff;
		real recip;
		recip = real'(RECIP15_MANT) * 2.0 ** (-RECIP15_SHIFT);
		r = '{16'd0, 16'd0, 1'b0};
		if (it.kind == KIND_HEADER) begin
			diff   = to_single(half_val(it.gmax) - half_val(it.gmin));
			p_step = to_half(to_single(diff * recip));
			p_min  = it.gmin;
			p_idx  = 0;
			return 0;
		end
		r.even = restore_code(it.dbyte[3:0]);
		r.odd  = restore_code(it.dbyte[7:4]);
		r.last = (p_idx >= GROUP_BYTES - 1);
		p_idx  = r.last ? 0 : p_idx + 1;
		return 1;
	endfunction

	// ---------------------------------------------------------------- stimulus build
	function automatic logic [15:0] rand_half();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom);
		return {1'($urandom), 5'($urandom_range(5, 20)), 10'($urandom)};
	endfunction

	function automatic stim_t mk(input logic k, input logic [15:0] a, input logic [15:0] b,
			input logic [7:0] d);
		return '{k, a, b, d, 1'b0, 16'd0, 16'd0, 1'b0};
	endfunction

	function automatic stim_t mk_typed(input logic [7:0] d, input logic [15:0] ev,
			input logic [15:0] od, input logic la);
		return '{KIND_DATA, 16'($urandom), 16'($urandom), d, 1'b1, ev, od, la};
	endfunction

	task automatic build_stimulus();
		int len;
		// data before any header: min and step are both +0.0
		stim.push_back(mk_typed(8'hFF, 16'h0000, 16'h0000, 1'b0));
		stim.push_back(mk_typed(8'h00, 16'h0000, 16'h0000, 1'b0));
		// 0..15 range gives unit step
		stim.push_back(mk(KIND_HEADER, 16'h0000, 16'h4B80, 8'h00));
		stim.push_back(mk(KIND_DATA, 16'h0000, 16'h0000, 8'hF0));
		stim.push_back(mk(KIND_DATA, 16'hFFFF, 16'hFFFF, 8'h5A));
		// infinite step: code 0 gives 0*inf = NaN, non-zero codes give +inf
		stim.push_back(mk(KIND_HEADER, 16'h0000, 16'h7C00, 8'h00));
		stim.push_back(mk_typed(8'h10, HALF_QNAN, 16'h7C00, 1'b0));
		// NaN minimum poisons everything
		stim.push_back(mk(KIND_HEADER, 16'h7E01, 16'h3C00, 8'h00));
		stim.push_back(mk_typed(8'hA5, HALF_QNAN, HALF_QNAN, 1'b0));
		// inf minus inf
		stim.push_back(mk(KIND_HEADER, 16'h7C00, 16'h7C00, 8'h00));
		stim.push_back(mk_typed(8'h3C, HALF_QNAN, HALF_QNAN, 1'b0));
		// full finite range, top codes may overflow to infinity
		stim.push_back(mk(KIND_HEADER, 16'hFBFF, 16'h7BFF, 8'h00));
		stim.push_back(mk(KIND_DATA, 16'h0000, 16'h0000, 8'hF0));
		stim.push_back(mk(KIND_DATA, 16'h0000, 16'h0000, 8'h0F));
		// subnormal range
		stim.push_back(mk(KIND_HEADER, 16'h0001, 16'h0010, 8'h00));
		stim.push_back(mk(KIND_DATA, 16'h0000, 16'h0000, 8'hF1));
		// negative step, max below min
		stim.push_back(mk(KIND_HEADER, 16'h3C00, 16'h8000, 8'h00));
		stim.push_back(mk(KIND_DATA, 16'h0000, 16'h0000, 8'h7E));
		// equal min and max, step zero
		stim.push_back(mk(KIND_HEADER, 16'hC500, 16'hC500, 8'h00));
		stim.push_back(mk(KIND_DATA, 16'h0000, 16'h0000, 8'hFF));
		// negative infinite step
		stim.push_back(mk(KIND_HEADER, 16'h7BFF, 16'hFC00, 8'h00));
		stim.push_back(mk(KIND_DATA, 16'h0000, 16'h0000, 8'h21));

		// random part: mostly full groups, some short, some running past the group end
		while (stim.size() < 500) begin
			if ($urandom_range(0, 9) != 0)
				stim.push_back(mk(KIND_HEADER, rand_half(), rand_half(), 8'($urandom)));
			case ($urandom_range(0, 5))
				0: len = $urandom_range(1, GROUP_BYTES - 1);
				1: len = GROUP_BYTES + $urandom_range(1, 12);
				default: len = GROUP_BYTES;
			endcase
			for (int i = 0; i < len; i++)
				stim.push_back(mk(KIND_DATA, 16'($urandom), 16'($urandom), 8'($urandom)));
		end
	endtask

	// ---------------------------------------------------------------- input driver
	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		din.valid      = 1'b0;
		din.kind       = KIND_HEADER;
		din.group_min  = 16'd0;
		din.group_max  = 16'd0;
		din.data_byte  = 8'd0;
		hold_req       = 1'b0;
		build_stimulus();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stim[i]) begin
			// items 150..260 go back to back
			if (i < 150 || i > 260) begin
				while ($urandom_range(0, 99) < IDLE_PCT) begin
					din.valid <= 1'b0;
					@(posedge clk);
				end
			end
			if (i == 300)
				hold_req = 1'b1;
			din.valid     <= 1'b1;
			din.kind      <= stim[i].kind;
			din.group_min <= stim[i].gmin;
			din.group_max <= stim[i].gmax;
			din.data_byte <= stim[i].dbyte;
			@(posedge clk);
			while (!din.ready)
				@(posedge clk);
		end
		din.valid <= 1'b0;
		while (pending_values.size() != 0 || n_accepted < stim.size())
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (n_fail == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// ---------------------------------------------------------------- result receiver
	initial begin
		int hold;
		dout.ready = 1'b0;
		hold       = 0;
		cyc        = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req && hold == 0) begin
				// long hold-off so the queue fills and din.ready drops
				hold_req = 1'b0;
				hold     = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				dout.ready <= 1'b0;
			end else if (cyc > 500 && cyc < 750) begin
				dout.ready <= 1'b1;
			end else begin
				dout.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// ---------------------------------------------------------------- input monitor
	always @(posedge clk or negedge arst_n) begin
		dq_res_t r;
		if (!arst_n) begin
			p_min      = 16'd0;
			p_step     = 16'd0;
			p_idx      = 0;
			n_accepted = 0;
		end else if (din.valid && din.ready) begin
			if (predict(stim[n_accepted], r)) begin
				if (stim[n_accepted].typed)
					r = '{stim[n_accepted].t_even, stim[n_accepted].t_odd,
						stim[n_accepted].t_last};
				pending_values.push_back(r);
			end
			n_accepted++;
		end
	end

	// ---------------------------------------------------------------- output checker
	always @(posedge clk) begin
		dq_res_t w;
		if (arst_n && dout.valid && dout.ready) begin
			if (pending_values.size() == 0) begin
				$error("unexpected result: even %h odd %h last %b",
					dout.value_even, dout.value_odd, dout.last_in_group);
				n_fail++;
			end else begin
				w = pending_values.pop_front();
				if (dout.value_even !== w.even) begin
					$error("value_even: expected %h actual %h", w.even, dout.value_even);
					n_fail++;
				end
				if (dout.value_odd !== w.odd) begin
					$error("value_odd: expected %h actual %h", w.odd, dout.value_odd);
					n_fail++;
				end
				if (dout.last_in_group !== w.last) begin
					$error("last_in_group: expected %b actual %b", w.last, dout.last_in_group);
					n_fail++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	initial begin
		n_fail = 0;
		#400000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
